/* rtl/core/seeded_shuffle_permutation_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the seeded shuffle permutation block.
// Each macro expands to one labelled concurrent assertion on clk, disabled
// while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SEEDED_SHUFFLE_PERMUTATION_ASSERT_SVH
`define SEEDED_SHUFFLE_PERMUTATION_ASSERT_SVH

// Same-cycle implication.
`define SSP_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ssp_pkg.sv */
// ---------------------------------------------------------------------------
// ssp_pkg
// Shared constants, codes and types of the seeded shuffle permutation block.
// ---------------------------------------------------------------------------
package ssp_pkg;

	// Grid and table sizing.
	localparam int MAX_GRID    = 64;
	localparam int TABLE_DEPTH = MAX_GRID * MAX_GRID;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int GRID_W      = 7;
	localparam int SEED_W      = 32;
	localparam int PROD_W      = 2 * SEED_W;

	// Generator constants.
	localparam logic [SEED_W-1:0] GOLDEN_STEP = 32'h6d2b_79f5;
	localparam logic [SEED_W-1:0] MIX_OR_A    = 32'd1;
	localparam logic [SEED_W-1:0] MIX_OR_B    = 32'd61;

	// Operation codes.
	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_SEED = 1'b0;
	localparam logic CFG_GRID = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_GRID_ZERO = 2'd1,
		STATUS_RANGE     = 2'd2,
		STATUS_NOT_BUILT = 2'd3
	} status_t;

	// Request from the sequencer to the draw unit.
	typedef struct packed {
		logic              load;
		logic [SEED_W-1:0] seed;
		logic              start;
		logic [CNT_W-1:0]  bound;
	} draw_req_t;

	// Response from the draw unit.
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] j;
	} draw_rsp_t;

endpackage

/* rtl/core/ssp_ram.sv */
// ---------------------------------------------------------------------------
// ssp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ssp_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ssp_draw.sv */
// ---------------------------------------------------------------------------
// ssp_draw
// Mulberry32 generator with scaling to a swap index, built around one
// shared registered 32x32 multiplier stepped by a small sequencer.
// ---------------------------------------------------------------------------
module ssp_draw (
	input  logic              clk,
	input  logic              arst_n,
	input  ssp_pkg::draw_req_t req,
	output ssp_pkg::draw_rsp_t rsp
);

	typedef enum logic [2:0] {
		D_IDLE,
		D_ADV,
		D_M1,
		D_M2,
		D_MIX,
		D_M3,
		D_OUT
	} dstate_t;

	dstate_t                          state_q;
	logic [ssp_pkg::SEED_W-1:0]       ctr_q;
	logic [ssp_pkg::SEED_W-1:0]       a_q;
	logic [ssp_pkg::SEED_W-1:0]       r_q;
	logic [ssp_pkg::CNT_W-1:0]        bound_q;
	logic [ssp_pkg::PROD_W-1:0]       prod_q;

	logic [ssp_pkg::SEED_W-1:0]       mul_a;
	logic [ssp_pkg::SEED_W-1:0]       mul_b;
	logic [ssp_pkg::SEED_W-1:0]       lo;
	logic [ssp_pkg::SEED_W-1:0]       t2;
	logic [ssp_pkg::SEED_W-1:0]       r_next;

	// Operand selection for the shared multiplier.
	always_comb begin
		lo     = prod_q[ssp_pkg::SEED_W-1:0];
		t2     = a_q ^ (a_q + lo);
		r_next = t2 ^ (t2 >> 14);
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			D_M1: begin
				mul_a = ctr_q ^ (ctr_q >> 15);
				mul_b = ctr_q | ssp_pkg::MIX_OR_A;
			end
			D_M2: begin
				mul_a = lo ^ (lo >> 7);
				mul_b = lo | ssp_pkg::MIX_OR_B;
			end
			D_M3: begin
				mul_a = r_q;
				mul_b = {{(ssp_pkg::SEED_W - ssp_pkg::CNT_W){1'b0}}, bound_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			ctr_q   <= '0;
			a_q     <= '0;
			r_q     <= '0;
			bound_q <= '0;
			prod_q  <= '0;
		end else begin
			if (req.load) begin
				ctr_q <= req.seed;
			end
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						bound_q <= req.bound;
						state_q <= D_ADV;
					end
				end
				D_ADV: begin
					ctr_q   <= ctr_q + ssp_pkg::GOLDEN_STEP;
					state_q <= D_M1;
				end
				D_M1: begin
					prod_q  <= mul_a * mul_b;
					state_q <= D_M2;
				end
				D_M2: begin
					a_q     <= lo;
					prod_q  <= mul_a * mul_b;
					state_q <= D_MIX;
				end
				D_MIX: begin
					r_q     <= r_next;
					state_q <= D_M3;
				end
				D_M3: begin
					prod_q  <= mul_a * mul_b;
					state_q <= D_OUT;
				end
				D_OUT: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// The high word of draw times bound never exceeds bound minus one.
	assign rsp.done = (state_q == D_OUT);
	assign rsp.j    = prod_q[ssp_pkg::SEED_W +: ssp_pkg::IDX_W];

endmodule

/* rtl/core/seeded_shuffle_permutation.sv */
// ---------------------------------------------------------------------------
// seeded_shuffle_permutation
// Builds a seeded random permutation of n = grid_side^2 entries (grid_side
// saturated at 64) and its inverse, and answers reads of both tables.
// ---------------------------------------------------------------------------
// Usage:
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the seed (index 0) and grid_side (index 1); it is always ready, and the
// user must write it only while the block is idle, which the block itself
// does not enforce. The input channel carries op and index; a transfer
// happens when in_valid is high and in_stall is low. Each item gives one
// result on the output channel, which transfers when out_valid is high and out_stall is low.
// A read registers the table memory read data, then loads the output
// register from it. A build runs an identity fill, a shuffle step per entry
// from the last down to the second (the draw unit's shared multiplier is
// used three times per step and the forward table has one read and one
// write port), and then the inverse pass. A build with grid_side zero
// builds nothing and answers with a grid-zero status. The block takes one
// item at a time; it accepts a new item while a finished result waits in
// the output register. A stalled receiver holds the result, and the block
// then waits before it can deliver its next one.
// Reset clears the control state; reads answer "not built" until the first
// successful build. The tables need no clearing pass.
// ---------------------------------------------------------------------------
`include "seeded_shuffle_permutation_assert.svh"

module seeded_shuffle_permutation (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [ssp_pkg::SEED_W-1:0]  cfg_data,
	// Input channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [ssp_pkg::IDX_W-1:0]   index,
	// Output channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ssp_pkg::IDX_W-1:0]   perm_value,
	output logic [ssp_pkg::IDX_W-1:0]   inv_value,
	output logic [1:0]                  status
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_DSTART,
		ST_DRAW,
		ST_RDJ,
		ST_WRI,
		ST_WRJ,
		ST_INV,
		ST_RESP
	} state_t;

	state_t                      state_q;
	logic [ssp_pkg::SEED_W-1:0]  seed_q;
	logic [ssp_pkg::GRID_W-1:0]  grid_q;
	logic                        built_q;
	logic [ssp_pkg::CNT_W-1:0]   count_q;
	logic [ssp_pkg::CNT_W-1:0]   n_q;
	logic [ssp_pkg::CNT_W-1:0]   k_q;
	logic [ssp_pkg::IDX_W-1:0]   i_q;
	logic [ssp_pkg::IDX_W-1:0]   j_q;
	logic [ssp_pkg::IDX_W-1:0]   a_q;
	logic                        rd_ok_q;
	ssp_pkg::status_t            status_q;
	logic                        pend_s1;
	logic [ssp_pkg::IDX_W-1:0]   k_s1;
	logic                        out_valid_q;
	logic [ssp_pkg::IDX_W-1:0]   perm_q;
	logic [ssp_pkg::IDX_W-1:0]   inv_q;
	logic [1:0]                  out_status_q;

	logic                        in_xfer;
	logic                        out_free;
	logic [ssp_pkg::GRID_W-1:0]  grid_sat;
	logic [ssp_pkg::CNT_W-1:0]   n_next;
	logic                        inv_rd;

	logic                        fwd_we;
	logic [ssp_pkg::IDX_W-1:0]   fwd_waddr;
	logic [ssp_pkg::IDX_W-1:0]   fwd_wdata;
	logic                        fwd_re;
	logic [ssp_pkg::IDX_W-1:0]   fwd_raddr;
	logic [ssp_pkg::IDX_W-1:0]   fwd_rdata;
	logic                        inv_we;
	logic                        inv_re;
	logic [ssp_pkg::IDX_W-1:0]   inv_rdata;

	ssp_pkg::draw_req_t          draw_req;
	ssp_pkg::draw_rsp_t          draw_rsp;

	// Handshake signals.
	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign perm_value = perm_q;
	assign inv_value  = inv_q;
	assign status     = out_status_q;

	// Entry count of a build, with the side saturated to the largest grid.
	always_comb begin
		if (grid_q > ssp_pkg::GRID_W'(ssp_pkg::MAX_GRID)) begin
			grid_sat = ssp_pkg::GRID_W'(ssp_pkg::MAX_GRID);
		end else begin
			grid_sat = grid_q;
		end
		n_next = ssp_pkg::CNT_W'(grid_sat) * ssp_pkg::CNT_W'(grid_sat);
	end

	// Table port control for every phase.
	always_comb begin
		inv_rd    = (state_q == ST_INV) && (k_q < n_q);
		fwd_we    = 1'b0;
		fwd_waddr = k_q[ssp_pkg::IDX_W-1:0];
		fwd_wdata = k_q[ssp_pkg::IDX_W-1:0];
		fwd_re    = 1'b0;
		fwd_raddr = index;
		case (state_q)
			ST_IDLE: begin
				fwd_re    = in_xfer && (op == ssp_pkg::OP_READ);
				fwd_raddr = index;
			end
			ST_FILL: begin
				fwd_we = 1'b1;
			end
			ST_DSTART: begin
				fwd_re    = 1'b1;
				fwd_raddr = i_q;
			end
			ST_RDJ: begin
				fwd_re    = 1'b1;
				fwd_raddr = j_q;
			end
			ST_WRI: begin
				fwd_we    = 1'b1;
				fwd_waddr = i_q;
				fwd_wdata = fwd_rdata;
			end
			ST_WRJ: begin
				fwd_we    = 1'b1;
				fwd_waddr = j_q;
				fwd_wdata = a_q;
			end
			ST_INV: begin
				fwd_re    = inv_rd;
				fwd_raddr = k_q[ssp_pkg::IDX_W-1:0];
			end
			default: begin
				fwd_re = 1'b0;
			end
		endcase
		inv_we = pend_s1;
		inv_re = (state_q == ST_IDLE) && in_xfer && (op == ssp_pkg::OP_READ);
	end

	// Requests to the draw unit.
	always_comb begin
		draw_req.load  = in_xfer && (op == ssp_pkg::OP_BUILD);
		draw_req.seed  = seed_q;
		draw_req.start = (state_q == ST_DSTART);
		draw_req.bound = {1'b0, i_q} + ssp_pkg::CNT_W'(1);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			grid_q <= ssp_pkg::GRID_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssp_pkg::CFG_SEED: seed_q <= cfg_data;
				ssp_pkg::CFG_GRID: grid_q <= cfg_data[ssp_pkg::GRID_W-1:0];
				default: seed_q <= seed_q;
			endcase
		end
	end

	// Sequencer, table state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			built_q      <= 1'b0;
			count_q      <= '0;
			n_q          <= '0;
			k_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			a_q          <= '0;
			rd_ok_q      <= 1'b0;
			status_q     <= ssp_pkg::STATUS_OK;
			pend_s1      <= 1'b0;
			k_s1         <= '0;
			out_valid_q  <= 1'b0;
			perm_q       <= '0;
			inv_q        <= '0;
			out_status_q <= '0;
		end else begin
			// The output register empties on a transfer unless a new result loads it.
			if (out_valid_q && !out_stall && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= inv_rd;
			k_s1    <= k_q[ssp_pkg::IDX_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						rd_ok_q <= 1'b0;
						state_q <= ST_RESP;
						if (op == ssp_pkg::OP_READ) begin
							if (!built_q) begin
								status_q <= ssp_pkg::STATUS_NOT_BUILT;
							end else if ({1'b0, index} >= count_q) begin
								status_q <= ssp_pkg::STATUS_RANGE;
							end else begin
								status_q <= ssp_pkg::STATUS_OK;
								rd_ok_q  <= 1'b1;
							end
						end else if (grid_q == '0) begin
							status_q <= ssp_pkg::STATUS_GRID_ZERO;
						end else begin
							status_q <= ssp_pkg::STATUS_OK;
							n_q      <= n_next;
							k_q      <= '0;
							state_q  <= ST_FILL;
						end
					end
				end
				// Identity fill of the forward table.
				ST_FILL: begin
					if (k_q == n_q - ssp_pkg::CNT_W'(1)) begin
						k_q <= '0;
						i_q <= k_q[ssp_pkg::IDX_W-1:0];
						if (n_q == ssp_pkg::CNT_W'(1)) begin
							state_q <= ST_INV;
						end else begin
							state_q <= ST_DSTART;
						end
					end else begin
						k_q <= k_q + ssp_pkg::CNT_W'(1);
					end
				end
				// One shuffle step: draw, read both entries, write both back.
				ST_DSTART: begin
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					if (draw_rsp.done) begin
						j_q     <= draw_rsp.j;
						a_q     <= fwd_rdata;
						state_q <= ST_RDJ;
					end
				end
				ST_RDJ: begin
					state_q <= ST_WRI;
				end
				ST_WRI: begin
					state_q <= ST_WRJ;
				end
				ST_WRJ: begin
					if (i_q == ssp_pkg::IDX_W'(1)) begin
						k_q     <= '0;
						state_q <= ST_INV;
					end else begin
						i_q     <= i_q - ssp_pkg::IDX_W'(1);
						state_q <= ST_DSTART;
					end
				end
				// Inverse pass: read forward entry, write its position in the cycle after.
				ST_INV: begin
					if (k_q == n_q) begin
						built_q <= 1'b1;
						count_q <= n_q;
						state_q <= ST_RESP;
					end else begin
						k_q <= k_q + ssp_pkg::CNT_W'(1);
					end
				end
				// Load the result once the output register is free.
				ST_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						perm_q       <= rd_ok_q ? fwd_rdata : '0;
						inv_q        <= rd_ok_q ? inv_rdata : '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Forward table.
	ssp_ram #(
		.WIDTH(ssp_pkg::IDX_W),
		.DEPTH(ssp_pkg::TABLE_DEPTH)
	) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_we),
		.waddr (fwd_waddr),
		.wdata (fwd_wdata),
		.re    (fwd_re),
		.raddr (fwd_raddr),
		.rdata (fwd_rdata)
	);

	// Inverse table; written from the forward read data during the inverse pass.
	ssp_ram #(
		.WIDTH(ssp_pkg::IDX_W),
		.DEPTH(ssp_pkg::TABLE_DEPTH)
	) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (fwd_rdata),
		.wdata (k_s1),
		.re    (inv_re),
		.raddr (index),
		.rdata (inv_rdata)
	);

	// Swap index generator.
	ssp_draw u_draw (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (draw_req),
		.rsp    (draw_rsp)
	);

	// A draw only completes while the sequencer waits for it.
	`SSP_ASSERT_IMP(a_draw_done_in_wait, clk, arst_n, draw_rsp.done,
		state_q == ST_DRAW, "draw finished outside the wait state")
	// Forward table writes stay inside the table being built.
	`SSP_ASSERT_IMP(a_fwd_write_in_range, clk, arst_n, fwd_we,
		{1'b0, fwd_waddr} < n_q, "forward write beyond entry count")
	// A build with a nonzero grid starts the identity fill.
	`SSP_ASSERT_NEXT(a_build_starts_fill, clk, arst_n,
		in_xfer && (op == ssp_pkg::OP_BUILD) && (grid_q != '0),
		state_q == ST_FILL, "build did not start the fill")
	// Once built, the tables stay built.
	`SSP_ASSERT_NEXT(a_built_sticky, clk, arst_n, built_q, built_q, "built flag cleared")

endmodule
